// File: rtl/core/plsu_pkg.sv
package plsu_pkg;

  // request codes
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_INSERT_AT  = 3'd4,
    ACT_ERASE_AT   = 3'd5,
    ACT_CLEAR      = 3'd6,
    ACT_SIZE       = 3'd7
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ERASE  = 2'd2
  } cell_op_t;

  localparam int POS_W = 5;
  localparam int CNT_OUT_W = 5;

  // popping the front of an empty store returns all ones
  localparam logic signed [31:0] POP_FRONT_EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic [2:0]         action;
    logic [POS_W-1:0]   position;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0]   removed_value;
    logic [CNT_OUT_W-1:0] count;
    logic [1:0]           status;
  } out_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/core/plsu_cell.sv
module plsu_cell
  import plsu_pkg::*;
(
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic               at_eq,
  input  logic               at_ge,
  input  logic signed [31:0] left_i,
  input  logic signed [31:0] right_i,
  output logic signed [31:0] data_o
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  // insert: the target takes the new value, cells past it take the left one
  // erase: the target and cells past it take the right one
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (at_eq) begin
          data_nxt = cmd.value;
        end else if (at_ge) begin
          data_nxt = left_i;
        end
      end
      CELL_ERASE: begin
        if (at_ge) begin
          data_nxt = right_i;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

// File: rtl/core/positional_list_store_unit.sv
// channel  | ports                        | payload
// input    | in_valid, in_ready, in_data  | in_t: action, position, value
// result   | out_valid, out_ready, out_data | out_t: removed_value, count, status
//
// one transaction per cycle while no result waits for out_ready: the whole row of
// cells shifts or holds in the cycle the request is accepted, and the result is registered with it
// the removed value comes from a one-hot select over the row before the shift
// reset (rst_n, synchronous) empties the store and drops any pending result
// in_ready stays high unless a result is held waiting for out_ready
module positional_list_store_unit
  import plsu_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic          out_valid_r;
  out_t          out_data_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  logic               in_fire;
  logic               full;
  logic               empty;
  logic [PW-1:0]      pos_w;
  logic [PW-1:0]      cnt_w;
  logic [PW-1:0]      at;
  cell_op_t           op;
  cell_cmd_t          cmd;
  status_t            status;
  logic signed [31:0] removed;
  logic signed [31:0] sel_value;
  logic [PW-1:0]      cnt_out_w;

  logic signed [31:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] at_eq;
  logic [CAPACITY-1:0] at_ge;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign pos_w    = PW'(in_data.position);
  assign cnt_w    = PW'(count_r);

  // request decode
  always_comb begin
    op        = CELL_HOLD;
    at        = '0;
    status    = ST_OK;
    removed   = '0;
    count_nxt = count_r;
    case (action_t'(in_data.action))
      ACT_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op        = CELL_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          op        = CELL_INSERT;
          at        = cnt_w;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status  = ST_EMPTY;
          removed = POP_FRONT_EMPTY_VALUE;
        end else begin
          op        = CELL_ERASE;
          removed   = sel_value;
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          op        = CELL_ERASE;
          at        = cnt_w - PW'(1);
          removed   = sel_value;
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_INSERT_AT: begin
        if (full) begin
          status = ST_FULL;
        end else if (pos_w > cnt_w) begin
          status = ST_RANGE;
        end else begin
          op        = CELL_INSERT;
          at        = pos_w;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_ERASE_AT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          op        = CELL_ERASE;
          at        = pos_w;
          removed   = sel_value;
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  // cells only move on an accepted transaction
  assign cmd.op    = in_fire ? op : CELL_HOLD;
  assign cmd.value = in_data.value;

  // row of cells with per-cell position compares
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_v;
    logic signed [31:0] right_v;

    assign at_eq[i] = (PW'(i) == at);
    assign at_ge[i] = (PW'(i) >= at);

    if (i == 0) begin : g_first
      assign left_v = in_data.value;
    end else begin : g_mid_l
      assign left_v = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_data[i];
    end else begin : g_mid_r
      assign right_v = cell_data[i+1];
    end

    plsu_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .at_eq   (at_eq[i]),
      .at_ge   (at_ge[i]),
      .left_i  (left_v),
      .right_i (right_v),
      .data_o  (cell_data[i])
    );
  end

  // one-hot select of the entry being removed
  always_comb begin
    sel_value = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_value = sel_value | (cell_data[k] & {32{at_eq[k]}});
    end
  end

  assign cnt_out_w = PW'(count_nxt);

  // fill count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.removed_value <= removed;
      out_data_r.count         <= cnt_out_w[CNT_OUT_W-1:0];
      out_data_r.status        <= status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && full && (in_data.action == ACT_PUSH_BACK) |=>
      (out_data.status == ST_FULL) && (count_r == $past(count_r)))
    else $error("push on full store changed the count");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !empty && (in_data.action == ACT_POP_FRONT) |=>
      (count_r == $past(count_r) - CW'(1)) && (out_data.status == ST_OK))
    else $error("pop front did not decrement the count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.action == ACT_CLEAR) |=> (count_r == '0) && out_valid)
    else $error("clear left entries in the store");
`endif

endmodule
